### hdl/source_tokenizer_core_macros.svh
// Assertion macros used by the token queue module
`ifndef SOURCE_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define STC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stc_pkg.sv
// Types and constants of the source tokenizer
package stc_pkg;

  localparam logic [4:0] M_IDLE    = 5'd0;
  localparam logic [4:0] M_COMMENT = 5'd1;
  localparam logic [4:0] M_EQ      = 5'd2;
  localparam logic [4:0] M_GT      = 5'd3;
  localparam logic [4:0] M_GT2     = 5'd4;
  localparam logic [4:0] M_LT      = 5'd5;
  localparam logic [4:0] M_LT2     = 5'd6;
  localparam logic [4:0] M_PLUS    = 5'd7;
  localparam logic [4:0] M_MINUS   = 5'd8;
  localparam logic [4:0] M_STAR    = 5'd9;
  localparam logic [4:0] M_SLASH   = 5'd10;
  localparam logic [4:0] M_PCT     = 5'd11;
  localparam logic [4:0] M_AMP     = 5'd12;
  localparam logic [4:0] M_PIPE    = 5'd13;
  localparam logic [4:0] M_CARET   = 5'd14;
  localparam logic [4:0] M_IDENT   = 5'd15;
  localparam logic [4:0] M_ZERO    = 5'd16;
  localparam logic [4:0] M_INT     = 5'd17;
  localparam logic [4:0] M_FRAC    = 5'd18;
  localparam logic [4:0] M_EXPS    = 5'd19;
  localparam logic [4:0] M_EXPD    = 5'd20;

  localparam logic [1:0] B_DEC = 2'd0;
  localparam logic [1:0] B_BIN = 2'd1;
  localparam logic [1:0] B_HEX = 2'd2;

  localparam logic [5:0] K_EOF       = 6'd0;
  localparam logic [5:0] K_LPAREN    = 6'd1;
  localparam logic [5:0] K_RPAREN    = 6'd2;
  localparam logic [5:0] K_LBRACK    = 6'd3;
  localparam logic [5:0] K_RBRACK    = 6'd4;
  localparam logic [5:0] K_LBRACE    = 6'd5;
  localparam logic [5:0] K_RBRACE    = 6'd6;
  localparam logic [5:0] K_SEMI      = 6'd7;
  localparam logic [5:0] K_COLON     = 6'd8;
  localparam logic [5:0] K_COMMA     = 6'd9;
  localparam logic [5:0] K_DOT       = 6'd10;
  localparam logic [5:0] K_EQEQ      = 6'd11;
  localparam logic [5:0] K_ASSIGN    = 6'd12;
  localparam logic [5:0] K_SHR_EQ    = 6'd13;
  localparam logic [5:0] K_SHR       = 6'd14;
  localparam logic [5:0] K_GE        = 6'd15;
  localparam logic [5:0] K_GT        = 6'd16;
  localparam logic [5:0] K_SHL_EQ    = 6'd17;
  localparam logic [5:0] K_SHL       = 6'd18;
  localparam logic [5:0] K_LE        = 6'd19;
  localparam logic [5:0] K_LT        = 6'd20;
  localparam logic [5:0] K_INC       = 6'd21;
  localparam logic [5:0] K_ADD_EQ    = 6'd22;
  localparam logic [5:0] K_ADD       = 6'd23;
  localparam logic [5:0] K_DEC       = 6'd24;
  localparam logic [5:0] K_ARROW     = 6'd25;
  localparam logic [5:0] K_SUB_EQ    = 6'd26;
  localparam logic [5:0] K_SUB       = 6'd27;
  localparam logic [5:0] K_MUL_EQ    = 6'd28;
  localparam logic [5:0] K_MUL       = 6'd29;
  localparam logic [5:0] K_DIV_EQ    = 6'd30;
  localparam logic [5:0] K_DIV       = 6'd31;
  localparam logic [5:0] K_MOD_EQ    = 6'd32;
  localparam logic [5:0] K_MOD       = 6'd33;
  localparam logic [5:0] K_LAND      = 6'd34;
  localparam logic [5:0] K_AND_EQ    = 6'd35;
  localparam logic [5:0] K_AND       = 6'd36;
  localparam logic [5:0] K_LOR       = 6'd37;
  localparam logic [5:0] K_OR_EQ     = 6'd38;
  localparam logic [5:0] K_OR        = 6'd39;
  localparam logic [5:0] K_XOR_EQ    = 6'd40;
  localparam logic [5:0] K_XOR       = 6'd41;
  localparam logic [5:0] K_INT       = 6'd42;
  localparam logic [5:0] K_FLOAT     = 6'd43;
  localparam logic [5:0] K_IDENTTOK  = 6'd44;
  localparam logic [5:0] K_ERR       = 6'd45;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } src_word_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_row;
    logic [15:0] start_col;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [63:0] integer_value;
    logic        value_overflow;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic       is_ws;
    logic       is_digit;
    logic       is_ident;
    logic       is_hex;
    logic [3:0] digit_val;
    logic [5:0] single_kind;
    logic [4:0] op_mode;
  } byte_class_t;

  typedef struct packed {
    src_word_t   word;
    byte_class_t cls;
  } class_word_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } tok_wr_t;

endpackage

### hdl/stc_front.sv
// Front end: accept source words, classify each byte, hold them in a two-entry queue
module stc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  stc_pkg::src_word_t         in_data_i,
  output logic                       cw_valid_o,
  input  logic                       cw_ready_i,
  output stc_pkg::class_word_t       cw_data_o
);

  function automatic stc_pkg::byte_class_t classify(input logic [7:0] c);
    stc_pkg::byte_class_t r;
    r = '0;
    r.op_mode = stc_pkg::M_IDLE;
    r.single_kind = stc_pkg::K_EOF;
    r.is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
              (c == 8'h0C) || (c == 8'h0D);
    r.is_digit = (c >= "0") && (c <= "9");
    if (r.is_digit) begin
      r.is_hex = 1'b1;
      r.digit_val = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      r.is_hex = 1'b1;
      r.digit_val = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      r.is_hex = 1'b1;
      r.digit_val = 4'(c - "A" + 8'd10);
    end
    r.is_ident = r.is_digit || ((c >= "a") && (c <= "z")) ||
                 ((c >= "A") && (c <= "Z")) || (c == stc_pkg::CH_UNDER);
    case (c)
      "(": r.single_kind = stc_pkg::K_LPAREN;
      ")": r.single_kind = stc_pkg::K_RPAREN;
      "[": r.single_kind = stc_pkg::K_LBRACK;
      "]": r.single_kind = stc_pkg::K_RBRACK;
      "{": r.single_kind = stc_pkg::K_LBRACE;
      "}": r.single_kind = stc_pkg::K_RBRACE;
      ";": r.single_kind = stc_pkg::K_SEMI;
      ":": r.single_kind = stc_pkg::K_COLON;
      ",": r.single_kind = stc_pkg::K_COMMA;
      ".": r.single_kind = stc_pkg::K_DOT;
      "=": r.op_mode = stc_pkg::M_EQ;
      ">": r.op_mode = stc_pkg::M_GT;
      "<": r.op_mode = stc_pkg::M_LT;
      "+": r.op_mode = stc_pkg::M_PLUS;
      "-": r.op_mode = stc_pkg::M_MINUS;
      "*": r.op_mode = stc_pkg::M_STAR;
      "/": r.op_mode = stc_pkg::M_SLASH;
      "%": r.op_mode = stc_pkg::M_PCT;
      "&": r.op_mode = stc_pkg::M_AMP;
      "|": r.op_mode = stc_pkg::M_PIPE;
      "^": r.op_mode = stc_pkg::M_CARET;
      default: r.op_mode = stc_pkg::M_IDLE;
    endcase
    return r;
  endfunction

  stc_pkg::class_word_t q_mem [2];
  logic                 wptr_q, rptr_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign cw_valid_o = (cnt_q != 2'd0);
  assign pop        = cw_valid_o && cw_ready_i;
  assign cw_data_o  = q_mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= '{word: in_data_i, cls: classify(in_data_i.source_byte)};
    end
  end

endmodule

### hdl/stc_lexer.sv
// Back end: longest-match lexer state, one word per cycle if room_i, up to two tokens out
module stc_lexer #(
  parameter int ROW_BITS    = 24,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cw_valid_i,
  output logic                 cw_ready_o,
  input  stc_pkg::class_word_t cw_data_i,
  input  logic                 room_i,
  output stc_pkg::tok_wr_t     wr_o
);

  function automatic logic [5:0] flush_kind(input logic [4:0] m, input logic fl);
    logic [5:0] k;
    case (m)
      stc_pkg::M_EQ:    k = stc_pkg::K_ASSIGN;
      stc_pkg::M_GT:    k = stc_pkg::K_GT;
      stc_pkg::M_GT2:   k = stc_pkg::K_SHR;
      stc_pkg::M_LT:    k = stc_pkg::K_LT;
      stc_pkg::M_LT2:   k = stc_pkg::K_SHL;
      stc_pkg::M_PLUS:  k = stc_pkg::K_ADD;
      stc_pkg::M_MINUS: k = stc_pkg::K_SUB;
      stc_pkg::M_STAR:  k = stc_pkg::K_MUL;
      stc_pkg::M_SLASH: k = stc_pkg::K_DIV;
      stc_pkg::M_PCT:   k = stc_pkg::K_MOD;
      stc_pkg::M_AMP:   k = stc_pkg::K_AND;
      stc_pkg::M_PIPE:  k = stc_pkg::K_OR;
      stc_pkg::M_CARET: k = stc_pkg::K_XOR;
      stc_pkg::M_IDENT: k = stc_pkg::K_IDENTTOK;
      default:          k = fl ? stc_pkg::K_FLOAT : stc_pkg::K_INT;
    endcase
    return k;
  endfunction

  logic [4:0]             mode_q, mode_d;
  logic [1:0]             base_q, base_d;
  logic                   float_q, float_d;
  logic [63:0]            acc_q, acc_d;
  logic                   aovf_q, aovf_d;
  logic [15:0]            len_q, len_d;
  logic [ROW_BITS-1:0]    row_q, row_d, trow_q, trow_d;
  logic [COL_BITS-1:0]    col_q, col_d, tcol_q, tcol_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, toff_q, toff_d;

  logic                   fire;
  logic [7:0]             c;
  stc_pkg::byte_class_t   cls;
  logic                   dig_ok, is_exp, absorbed, e0, e1;
  logic [5:0]             k0, k1;
  logic [15:0]            l0, grown;
  logic [67:0]            prod, sum;
  logic                   acc_ovf;
  stc_pkg::token_t        ta, tb;

  assign fire       = cw_valid_i && room_i;
  assign cw_ready_o = room_i;
  assign c          = cw_data_i.word.source_byte;
  assign cls        = cw_data_i.cls;
  assign grown      = (len_q == 16'hFFFF) ? len_q : 16'(len_q + 16'd1);

  always_comb begin
    case (base_q)
      stc_pkg::B_BIN: dig_ok = (c == "0") || (c == "1");
      stc_pkg::B_HEX: dig_ok = cls.is_hex;
      default:        dig_ok = cls.is_digit;
    endcase
    case (base_q)
      stc_pkg::B_DEC: is_exp = (c == stc_pkg::CH_E_LO) || (c == stc_pkg::CH_E_UP);
      stc_pkg::B_HEX: is_exp = (c == stc_pkg::CH_P_LO) || (c == stc_pkg::CH_P_UP);
      default:        is_exp = 1'b0;
    endcase
    case (base_q)
      stc_pkg::B_BIN: prod = {3'b0, acc_q, 1'b0};
      stc_pkg::B_HEX: prod = {acc_q, 4'b0};
      default:        prod = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
    endcase
    sum     = prod + {64'b0, cls.digit_val};
    acc_ovf = aovf_q || (sum[67:64] != 4'd0);
  end

  always_comb begin
    mode_d   = mode_q;
    base_d   = base_q;
    float_d  = float_q;
    acc_d    = acc_q;
    aovf_d   = aovf_q;
    len_d    = len_q;
    row_d    = row_q;
    col_d    = col_q;
    off_d    = off_q;
    trow_d   = trow_q;
    tcol_d   = tcol_q;
    toff_d   = toff_q;
    absorbed = 1'b0;
    e0       = 1'b0;
    e1       = 1'b0;
    k0       = flush_kind(mode_q, float_q);
    k1       = stc_pkg::K_EOF;
    l0       = len_q;
    if (fire && cw_data_i.word.end_of_input) begin
      if ((mode_q != stc_pkg::M_IDLE) && (mode_q != stc_pkg::M_COMMENT)) begin
        e0 = 1'b1;
      end
      mode_d = stc_pkg::M_IDLE;
      e1     = 1'b1;
      k1     = stc_pkg::K_EOF;
    end else if (fire) begin
      case (mode_q)
        stc_pkg::M_IDLE: absorbed = 1'b0;
        stc_pkg::M_COMMENT: begin
          if (c == stc_pkg::CH_LF) mode_d = stc_pkg::M_IDLE;
          else absorbed = 1'b1;
        end
        stc_pkg::M_EQ: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_EQEQ; end
        end
        stc_pkg::M_GT: begin
          if (c == ">") begin
            absorbed = 1'b1;
            len_d = grown;
            mode_d = stc_pkg::M_GT2;
          end else if (c == "=") begin
            absorbed = 1'b1; k0 = stc_pkg::K_GE;
          end
        end
        stc_pkg::M_GT2: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_SHR_EQ; end
        end
        stc_pkg::M_LT: begin
          if (c == "<") begin
            absorbed = 1'b1;
            len_d = grown;
            mode_d = stc_pkg::M_LT2;
          end else if (c == "=") begin
            absorbed = 1'b1; k0 = stc_pkg::K_LE;
          end
        end
        stc_pkg::M_LT2: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_SHL_EQ; end
        end
        stc_pkg::M_PLUS: begin
          if (c == "+") begin absorbed = 1'b1; k0 = stc_pkg::K_INC; end
          else if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_ADD_EQ; end
        end
        stc_pkg::M_MINUS: begin
          if (c == "-") begin absorbed = 1'b1; k0 = stc_pkg::K_DEC; end
          else if (c == ">") begin absorbed = 1'b1; k0 = stc_pkg::K_ARROW; end
          else if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_SUB_EQ; end
        end
        stc_pkg::M_STAR: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_MUL_EQ; end
        end
        stc_pkg::M_SLASH: begin
          if (c == "/") begin
            absorbed = 1'b1;
            mode_d = stc_pkg::M_COMMENT;
          end else if (c == "=") begin
            absorbed = 1'b1; k0 = stc_pkg::K_DIV_EQ;
          end
        end
        stc_pkg::M_PCT: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_MOD_EQ; end
        end
        stc_pkg::M_AMP: begin
          if (c == "&") begin absorbed = 1'b1; k0 = stc_pkg::K_LAND; end
          else if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_AND_EQ; end
        end
        stc_pkg::M_PIPE: begin
          if (c == "|") begin absorbed = 1'b1; k0 = stc_pkg::K_LOR; end
          else if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_OR_EQ; end
        end
        stc_pkg::M_CARET: begin
          if (c == "=") begin absorbed = 1'b1; k0 = stc_pkg::K_XOR_EQ; end
        end
        stc_pkg::M_IDENT: begin
          if (cls.is_ident) begin absorbed = 1'b1; len_d = grown; end
        end
        stc_pkg::M_ZERO, stc_pkg::M_INT: begin
          if ((mode_q == stc_pkg::M_ZERO) && (c == stc_pkg::CH_B)) begin
            absorbed = 1'b1; len_d = grown;
            base_d = stc_pkg::B_BIN; mode_d = stc_pkg::M_INT;
          end else if ((mode_q == stc_pkg::M_ZERO) && (c == stc_pkg::CH_X)) begin
            absorbed = 1'b1; len_d = grown;
            base_d = stc_pkg::B_HEX; mode_d = stc_pkg::M_INT;
          end else if (dig_ok) begin
            absorbed = 1'b1; len_d = grown; mode_d = stc_pkg::M_INT;
            acc_d  = acc_ovf ? {64{1'b1}} : sum[63:0];
            aovf_d = acc_ovf;
          end else if (c == ".") begin
            absorbed = 1'b1; len_d = grown;
            float_d = 1'b1; mode_d = stc_pkg::M_FRAC;
          end else if (is_exp) begin
            absorbed = 1'b1; len_d = grown;
            float_d = 1'b1; mode_d = stc_pkg::M_EXPS;
          end
        end
        stc_pkg::M_FRAC: begin
          if (dig_ok) begin
            absorbed = 1'b1; len_d = grown;
          end else if (is_exp) begin
            absorbed = 1'b1; len_d = grown; mode_d = stc_pkg::M_EXPS;
          end
        end
        stc_pkg::M_EXPS: begin
          if ((c == "+") || (c == "-") || cls.is_digit) begin
            absorbed = 1'b1; len_d = grown; mode_d = stc_pkg::M_EXPD;
          end
        end
        stc_pkg::M_EXPD: begin
          if (cls.is_digit) begin absorbed = 1'b1; len_d = grown; end
        end
        default: mode_d = stc_pkg::M_IDLE;
      endcase

      if ((mode_q != stc_pkg::M_IDLE) && (mode_q != stc_pkg::M_COMMENT) &&
          (mode_q <= stc_pkg::M_EXPD)) begin
        if (!absorbed) begin
          e0 = 1'b1;
          mode_d = stc_pkg::M_IDLE;
        end else if (k0 != flush_kind(mode_q, float_q)) begin
          e0 = 1'b1;
          l0 = grown;
          mode_d = stc_pkg::M_IDLE;
        end
      end

      if (!absorbed) begin
        trow_d = row_q;
        tcol_d = col_q;
        toff_d = off_q;
        len_d  = 16'd1;
        mode_d = stc_pkg::M_IDLE;
        if (cls.is_ws) begin
          mode_d = stc_pkg::M_IDLE;
        end else if (cls.single_kind != stc_pkg::K_EOF) begin
          e1 = 1'b1;
          k1 = cls.single_kind;
        end else if (cls.op_mode != stc_pkg::M_IDLE) begin
          mode_d = cls.op_mode;
        end else if (cls.is_digit) begin
          base_d  = stc_pkg::B_DEC;
          float_d = 1'b0;
          acc_d   = {60'b0, cls.digit_val};
          aovf_d  = 1'b0;
          mode_d  = (c == "0") ? stc_pkg::M_ZERO : stc_pkg::M_INT;
        end else if (cls.is_ident) begin
          mode_d = stc_pkg::M_IDENT;
        end else begin
          e1 = 1'b1;
          k1 = stc_pkg::K_ERR;
        end
      end

      off_d = OFFSET_BITS'(off_q + 1'b1);
      if (c == stc_pkg::CH_LF) begin
        if (row_q != {ROW_BITS{1'b1}}) row_d = ROW_BITS'(row_q + 1'b1);
        col_d = COL_BITS'(1);
      end else if (col_q != {COL_BITS{1'b1}}) begin
        col_d = COL_BITS'(col_q + 1'b1);
      end
    end
  end

  always_comb begin
    ta.token_kind     = k0;
    ta.start_row      = 24'(64'(trow_q));
    ta.start_col      = 16'(64'(tcol_q));
    ta.start_offset   = 32'(64'(toff_q));
    ta.token_length   = l0;
    ta.integer_value  = (k0 == stc_pkg::K_INT) ? acc_q : 64'd0;
    ta.value_overflow = (k0 == stc_pkg::K_INT) && aovf_q;
    ta.last_of_run    = !e1;
    tb.token_kind     = k1;
    tb.start_row      = 24'(64'(row_q));
    tb.start_col      = 16'(64'(col_q));
    tb.start_offset   = 32'(64'(off_q));
    tb.token_length   = (k1 == stc_pkg::K_EOF) ? 16'd0 : 16'd1;
    tb.integer_value  = 64'd0;
    tb.value_overflow = 1'b0;
    tb.last_of_run    = 1'b1;
    wr_o.count = 2'({1'b0, e0} + {1'b0, e1});
    wr_o.tok0  = e0 ? ta : tb;
    wr_o.tok1  = tb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stc_pkg::M_IDLE;
      base_q  <= stc_pkg::B_DEC;
      float_q <= 1'b0;
      acc_q   <= 64'd0;
      aovf_q  <= 1'b0;
      len_q   <= 16'd0;
      row_q   <= ROW_BITS'(1);
      col_q   <= COL_BITS'(1);
      off_q   <= '0;
      trow_q  <= ROW_BITS'(1);
      tcol_q  <= COL_BITS'(1);
      toff_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      base_q  <= base_d;
      float_q <= float_d;
      acc_q   <= acc_d;
      aovf_q  <= aovf_d;
      len_q   <= len_d;
      row_q   <= row_d;
      col_q   <= col_d;
      off_q   <= off_d;
      trow_q  <= trow_d;
      tcol_q  <= tcol_d;
      toff_q  <= toff_d;
    end
  end

endmodule

### hdl/stc_tok_queue.sv
// Token queue: up to two tokens in a cycle, one out a cycle while ready
`include "source_tokenizer_core_macros.svh"
module stc_tok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stc_pkg::tok_wr_t wr_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stc_pkg::token_t  out_data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  stc_pkg::token_t mem [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;

  assign room_o      = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= PtrW'(wptr_q + wr_i.count);
      if (pop) rptr_q <= PtrW'(rptr_q + 1'b1);
      cnt_q <= (PtrW+1)'(cnt_q + wr_i.count - {{PtrW{1'b0}}, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) mem[wptr_q] <= wr_i.tok0;
    if (wr_i.count == 2'd2) mem[PtrW'(wptr_q + 1'b1)] <= wr_i.tok1;
  end

  `STC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (PtrW+1)'(Depth), "token queue overfilled")
  `STC_ASSERT_IMP(a_wr_room, wr_i.count != 2'd0, room_o, "tokens written without room")
  `STC_ASSERT_NXT(a_stall_hold, out_valid_o && !out_ready_i, cnt_q >= $past(cnt_q),
                  "stalled queue lost a word")
  `STC_ASSERT_IMP(a_wr_count, 1'b1, wr_i.count != 2'd3, "more than two tokens in a cycle")

endmodule

### hdl/source_tokenizer_core.sv
// Top level of the source tokenizer: front queue, lexer and token queue
//
//  channel | direction | word                 | handshake
//  in      | input     | src_word_t  (byte/EOI) | in_valid_i / in_ready_o
//  out     | output    | token_t     (token)    | out_valid_o / out_ready_i
//
//  One word a cycle while the lexer has room; a token is offered once the token queue holds it.
//  The lexer state register loop is the step that sets this rate.
//  Each word yields zero, one or two tokens; the lexer waits while fewer than two slots are free.
//  Reset (rst_ni low) clears all queues and returns the lexer to idle at row 1, column 1, offset 0.
//  A stalled output fills the token queue, then the front queue, then drops in_ready_o.
module source_tokenizer_core #(
  parameter int ROW_BITS    = 24,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stc_pkg::src_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stc_pkg::token_t    out_data_o
);

  logic                 cw_valid, cw_ready, room;
  stc_pkg::class_word_t cw_data;
  stc_pkg::tok_wr_t     wr;

  stc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cw_valid_o (cw_valid),
    .cw_ready_i (cw_ready),
    .cw_data_o  (cw_data)
  );

  stc_lexer #(
    .ROW_BITS    (ROW_BITS),
    .COL_BITS    (COL_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cw_valid_i (cw_valid),
    .cw_ready_o (cw_ready),
    .cw_data_i  (cw_data),
    .room_i     (room),
    .wr_o       (wr)
  );

  stc_tok_queue u_tok_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/tb_top.sv
// Testbench for the source tokenizer: directed and random byte streams checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  stc_pkg::src_word_t in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  stc_pkg::token_t    out_data_o;

  source_tokenizer_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer copy
  logic [4:0]      lx_mode;
  logic [1:0]      lx_base;
  logic            lx_float;
  logic [63:0]     lx_acc;
  logic            lx_ovf;
  logic [23:0]     cur_row, tok_row;
  logic [15:0]     cur_col, tok_col;
  logic [31:0]     cur_off, tok_off;
  logic [15:0]     tok_len;
  stc_pkg::token_t pending_tokens[$];
  int              run_cnt;

  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic void lx_emit(logic [5:0] kind, logic [23:0] r, logic [15:0] c,
                                  logic [31:0] o, logic [15:0] l, logic [63:0] v, logic f);
    stc_pkg::token_t t;
    if (run_cnt >= 2) return;
    t.token_kind = kind; t.start_row = r; t.start_col = c; t.start_offset = o;
    t.token_length = l; t.integer_value = v; t.value_overflow = f; t.last_of_run = 1'b0;
    pending_tokens.push_back(t);
    run_cnt++;
  endfunction

  function automatic void emit_tok(logic [5:0] kind);
    logic is_int;
    is_int = (kind == stc_pkg::K_INT);
    lx_emit(kind, tok_row, tok_col, tok_off, tok_len, is_int ? lx_acc : 64'd0,
            is_int & lx_ovf);
    lx_mode = stc_pkg::M_IDLE;
  endfunction

  function automatic void grow_tok();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic void finish_tok(logic [5:0] kind);
    grow_tok();
    emit_tok(kind);
  endfunction

  function automatic int digit_val(logic [7:0] c, logic [1:0] b);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = int'(c - "0");
    else if (c >= "a" && c <= "f") d = int'(c - "a") + 10;
    else if (c >= "A" && c <= "F") d = int'(c - "A") + 10;
    if (b == stc_pkg::B_BIN) return (d == 0 || d == 1) ? d : -1;
    if (b == stc_pkg::B_HEX) return d;
    return (d >= 0 && d <= 9) ? d : -1;
  endfunction

  function automatic bit is_exp_char(logic [7:0] c);
    if (lx_base == stc_pkg::B_DEC) return c == stc_pkg::CH_E_LO || c == stc_pkg::CH_E_UP;
    if (lx_base == stc_pkg::B_HEX) return c == stc_pkg::CH_P_LO || c == stc_pkg::CH_P_UP;
    return 1'b0;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == stc_pkg::CH_UNDER;
  endfunction

  function automatic void add_digit(int d);
    logic [127:0] prod;
    logic [63:0]  b;
    b = (lx_base == stc_pkg::B_BIN) ? 64'd2 : (lx_base == stc_pkg::B_HEX) ? 64'd16 : 64'd10;
    prod = {64'd0, lx_acc} * {64'd0, b} + 128'(d);
    if (lx_ovf || prod[127:64] != 64'd0) begin
      lx_acc = '1;
      lx_ovf = 1'b1;
    end else begin
      lx_acc = prod[63:0];
    end
  endfunction

  function automatic bit extend_tok(logic [7:0] c);
    int d;
    case (lx_mode)
      stc_pkg::M_COMMENT: begin
        if (c == stc_pkg::CH_LF) begin lx_mode = stc_pkg::M_IDLE; return 1'b0; end
        return 1'b1;
      end
      stc_pkg::M_EQ: begin
        if (c == "=") begin finish_tok(stc_pkg::K_EQEQ); return 1'b1; end
        emit_tok(stc_pkg::K_ASSIGN); return 1'b0;
      end
      stc_pkg::M_GT: begin
        if (c == ">") begin grow_tok(); lx_mode = stc_pkg::M_GT2; return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_GE); return 1'b1; end
        emit_tok(stc_pkg::K_GT); return 1'b0;
      end
      stc_pkg::M_GT2: begin
        if (c == "=") begin finish_tok(stc_pkg::K_SHR_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_SHR); return 1'b0;
      end
      stc_pkg::M_LT: begin
        if (c == "<") begin grow_tok(); lx_mode = stc_pkg::M_LT2; return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_LE); return 1'b1; end
        emit_tok(stc_pkg::K_LT); return 1'b0;
      end
      stc_pkg::M_LT2: begin
        if (c == "=") begin finish_tok(stc_pkg::K_SHL_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_SHL); return 1'b0;
      end
      stc_pkg::M_PLUS: begin
        if (c == "+") begin finish_tok(stc_pkg::K_INC); return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_ADD_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_ADD); return 1'b0;
      end
      stc_pkg::M_MINUS: begin
        if (c == "-") begin finish_tok(stc_pkg::K_DEC); return 1'b1; end
        if (c == ">") begin finish_tok(stc_pkg::K_ARROW); return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_SUB_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_SUB); return 1'b0;
      end
      stc_pkg::M_STAR: begin
        if (c == "=") begin finish_tok(stc_pkg::K_MUL_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_MUL); return 1'b0;
      end
      stc_pkg::M_SLASH: begin
        if (c == "/") begin lx_mode = stc_pkg::M_COMMENT; return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_DIV_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_DIV); return 1'b0;
      end
      stc_pkg::M_PCT: begin
        if (c == "=") begin finish_tok(stc_pkg::K_MOD_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_MOD); return 1'b0;
      end
      stc_pkg::M_AMP: begin
        if (c == "&") begin finish_tok(stc_pkg::K_LAND); return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_AND_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_AND); return 1'b0;
      end
      stc_pkg::M_PIPE: begin
        if (c == "|") begin finish_tok(stc_pkg::K_LOR); return 1'b1; end
        if (c == "=") begin finish_tok(stc_pkg::K_OR_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_OR); return 1'b0;
      end
      stc_pkg::M_CARET: begin
        if (c == "=") begin finish_tok(stc_pkg::K_XOR_EQ); return 1'b1; end
        emit_tok(stc_pkg::K_XOR); return 1'b0;
      end
      stc_pkg::M_IDENT: begin
        if (is_word_char(c)) begin grow_tok(); return 1'b1; end
        emit_tok(stc_pkg::K_IDENTTOK); return 1'b0;
      end
      stc_pkg::M_ZERO, stc_pkg::M_INT: begin
        if (lx_mode == stc_pkg::M_ZERO) begin
          if (c == stc_pkg::CH_B) begin
            grow_tok(); lx_base = stc_pkg::B_BIN; lx_mode = stc_pkg::M_INT; return 1'b1;
          end
          if (c == stc_pkg::CH_X) begin
            grow_tok(); lx_base = stc_pkg::B_HEX; lx_mode = stc_pkg::M_INT; return 1'b1;
          end
          lx_mode = stc_pkg::M_INT;
        end
        d = digit_val(c, lx_base);
        if (d >= 0) begin grow_tok(); add_digit(d); return 1'b1; end
        if (c == ".") begin
          grow_tok(); lx_float = 1'b1; lx_mode = stc_pkg::M_FRAC; return 1'b1;
        end
        if (is_exp_char(c)) begin
          grow_tok(); lx_float = 1'b1; lx_mode = stc_pkg::M_EXPS; return 1'b1;
        end
      end
      stc_pkg::M_FRAC: begin
        if (digit_val(c, lx_base) >= 0) begin grow_tok(); return 1'b1; end
        if (is_exp_char(c)) begin grow_tok(); lx_mode = stc_pkg::M_EXPS; return 1'b1; end
      end
      stc_pkg::M_EXPS: begin
        if (c == "+" || c == "-" || (c >= "0" && c <= "9")) begin
          grow_tok(); lx_mode = stc_pkg::M_EXPD; return 1'b1;
        end
      end
      stc_pkg::M_EXPD: begin
        if (c >= "0" && c <= "9") begin grow_tok(); return 1'b1; end
      end
      default: begin
        lx_mode = stc_pkg::M_IDLE; return 1'b0;
      end
    endcase
    emit_tok(lx_float ? stc_pkg::K_FLOAT : stc_pkg::K_INT);
    return 1'b0;
  endfunction

  function automatic void flush_tok();
    case (lx_mode)
      stc_pkg::M_IDLE, stc_pkg::M_COMMENT: lx_mode = stc_pkg::M_IDLE;
      stc_pkg::M_EQ:    emit_tok(stc_pkg::K_ASSIGN);
      stc_pkg::M_GT:    emit_tok(stc_pkg::K_GT);
      stc_pkg::M_GT2:   emit_tok(stc_pkg::K_SHR);
      stc_pkg::M_LT:    emit_tok(stc_pkg::K_LT);
      stc_pkg::M_LT2:   emit_tok(stc_pkg::K_SHL);
      stc_pkg::M_PLUS:  emit_tok(stc_pkg::K_ADD);
      stc_pkg::M_MINUS: emit_tok(stc_pkg::K_SUB);
      stc_pkg::M_STAR:  emit_tok(stc_pkg::K_MUL);
      stc_pkg::M_SLASH: emit_tok(stc_pkg::K_DIV);
      stc_pkg::M_PCT:   emit_tok(stc_pkg::K_MOD);
      stc_pkg::M_AMP:   emit_tok(stc_pkg::K_AND);
      stc_pkg::M_PIPE:  emit_tok(stc_pkg::K_OR);
      stc_pkg::M_CARET: emit_tok(stc_pkg::K_XOR);
      stc_pkg::M_IDENT: emit_tok(stc_pkg::K_IDENTTOK);
      default:          emit_tok(lx_float ? stc_pkg::K_FLOAT : stc_pkg::K_INT);
    endcase
  endfunction

  function automatic void start_tok(logic [7:0] c);
    tok_row = cur_row; tok_col = cur_col; tok_off = cur_off; tok_len = 16'd1;
    case (c)
      " ", "\t", 8'h0A, 8'h0B, 8'h0C, 8'h0D: return;
      "(": begin emit_tok(stc_pkg::K_LPAREN); return; end
      ")": begin emit_tok(stc_pkg::K_RPAREN); return; end
      "[": begin emit_tok(stc_pkg::K_LBRACK); return; end
      "]": begin emit_tok(stc_pkg::K_RBRACK); return; end
      "{": begin emit_tok(stc_pkg::K_LBRACE); return; end
      "}": begin emit_tok(stc_pkg::K_RBRACE); return; end
      ";": begin emit_tok(stc_pkg::K_SEMI); return; end
      ":": begin emit_tok(stc_pkg::K_COLON); return; end
      ",": begin emit_tok(stc_pkg::K_COMMA); return; end
      ".": begin emit_tok(stc_pkg::K_DOT); return; end
      "=": begin lx_mode = stc_pkg::M_EQ; return; end
      ">": begin lx_mode = stc_pkg::M_GT; return; end
      "<": begin lx_mode = stc_pkg::M_LT; return; end
      "+": begin lx_mode = stc_pkg::M_PLUS; return; end
      "-": begin lx_mode = stc_pkg::M_MINUS; return; end
      "*": begin lx_mode = stc_pkg::M_STAR; return; end
      "/": begin lx_mode = stc_pkg::M_SLASH; return; end
      "%": begin lx_mode = stc_pkg::M_PCT; return; end
      "&": begin lx_mode = stc_pkg::M_AMP; return; end
      "|": begin lx_mode = stc_pkg::M_PIPE; return; end
      "^": begin lx_mode = stc_pkg::M_CARET; return; end
      default: ;
    endcase
    if (c >= "0" && c <= "9") begin
      lx_base = stc_pkg::B_DEC; lx_float = 1'b0; lx_acc = {56'd0, 8'(c - "0")};
      lx_ovf = 1'b0;
      lx_mode = (c == "0") ? stc_pkg::M_ZERO : stc_pkg::M_INT;
      return;
    end
    if (is_word_char(c)) begin lx_mode = stc_pkg::M_IDENT; return; end
    emit_tok(stc_pkg::K_ERR);
  endfunction

  function automatic void lex_word(stc_pkg::src_word_t w);
    run_cnt = 0;
    if (w.end_of_input) begin
      flush_tok();
      lx_emit(stc_pkg::K_EOF, cur_row, cur_col, cur_off, 16'd0, 64'd0, 1'b0);
    end else begin
      if (lx_mode == stc_pkg::M_IDLE || !extend_tok(w.source_byte)) start_tok(w.source_byte);
      cur_off++;
      if (w.source_byte == stc_pkg::CH_LF) begin
        if (cur_row != 24'hFFFFFF) cur_row++;
        cur_col = 16'd1;
      end else if (cur_col != 16'hFFFF) begin
        cur_col++;
      end
    end
    if (run_cnt > 0) pending_tokens[$].last_of_run = 1'b1;
  endfunction

  task automatic send_word(logic [7:0] c, logic eoi);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= '{source_byte: c, end_of_input: eoi};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lex_word(in_data_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", out_data_o);
      end else begin
        if (out_data_o !== pending_tokens[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: expected %p actual %p", pending_tokens[0], out_data_o);
        end
        void'(pending_tokens.pop_front());
      end
    end
  end

  task automatic test_directed();
    send_text("()[]{};:,. == = >>= >> >= > <<= << <= < ++ += + -- -> -= - ");
    send_text("*= * /= / %= % && &= & || |= | ^= ^\tabc_9 Z\r\v\f");
    send_word(8'h00, 1'b0); send_word(8'h80, 1'b0); send_word(8'hFF, 1'b0);
    send_word("@", 1'b0);
    send_text("0 0b 0x 0b101 0xFfA 0xg 12.5e+3 1E9 0x1.8p-2 0b1e 0b12 3.e 7p ");
    send_text("18446744073709551615 18446744073709551616 0xFFFFFFFFFFFFFFFFF // hi\n");
    send_text("a//x");
    send_word(8'h00, 1'b1);
    send_text("x");
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b1);
    send_text("-");
    send_word(8'h00, 1'b1);
    drain();
  endtask

  task automatic random_item();
    string frags[$] = '{"foo", "_x1", "0b1011", "0x1F", "0xabP+3", "12.75e-4", "1e",
                        "99999999999999999999", "0", ">>=", "<<", "->", "&&", "//c\n",
                        "\n", " ", "\t", "+=", "0.5", "0b", "0x", "=", "|", "^="};
    string f;
    int k;
    k = int'($urandom_range(99));
    if (k < 8) send_word(8'($urandom_range(255)), 1'b0);
    else if (k < 10) send_word(8'($urandom_range(255)), 1'b1);
    else begin
      f = frags[$urandom_range(frags.size() - 1)];
      if (f.len() > 1 && $urandom_range(9) == 0) f = f.substr(0, f.len() - 2);
      send_text(f);
    end
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) random_item();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (150) send_text("( ");
    join
    drain();
  endtask

  task automatic test_deep_lines();
    // build a long identifier, then many short rows
    repeat (40) send_word("a", 1'b0);
    repeat (12) send_text("ab\n");
    send_word(" ", 1'b0);
    send_word(8'h00, 1'b1);
    drain();
  endtask

  initial begin
    lx_mode = stc_pkg::M_IDLE; lx_base = stc_pkg::B_DEC; lx_float = 1'b0; lx_acc = 64'd0;
    lx_ovf = 1'b0;
    cur_row = 24'd1; cur_col = 16'd1; cur_off = 32'd0;
    tok_row = 24'd1; tok_col = 16'd1; tok_off = 32'd0;
    tok_len = 16'd0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(0, 0, 55);
    test_random_phase(71, 0, 55);
    test_random_phase(0, 71, 55);
    test_random_phase(16, 16, 55);
    drain();
    test_backpressure();
    test_random_phase(0, 0, 45);
    send_word(8'h00, 1'b1);
    drain();
    test_deep_lines();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
